// ----- rtl/core/vfrt_pkg.sv -----
// Shared word types and constants of the view-facing ribbon trail block.
package vfrt_pkg;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] fwd_x;
        logic signed [31:0] fwd_y;
        logic signed [31:0] fwd_z;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] top_x;
        logic signed [31:0] top_y;
        logic signed [31:0] top_z;
        logic signed [31:0] bottom_x;
        logic signed [31:0] bottom_y;
        logic signed [31:0] bottom_z;
        logic [1:0]         outcome;
        logic [5:0]         slot;
        logic [5:0]         head_index;
        logic [5:0]         tail_index;
    } t_out_word;

    localparam logic [2:0] CFG_VIEW_X     = 3'd0;
    localparam logic [2:0] CFG_VIEW_Y     = 3'd1;
    localparam logic [2:0] CFG_VIEW_Z     = 3'd2;
    localparam logic [2:0] CFG_LINE_WIDTH = 3'd3;
    localparam logic [2:0] CFG_ENTRIES    = 3'd4;

    localparam logic [1:0] OUT_STORED  = 2'd0;
    localparam logic [1:0] OUT_SKIPPED = 2'd1;
    localparam logic [1:0] OUT_FAILED  = 2'd2;

    // 0.5 in Q32.32, 0.99 in Q.46 and 0.05 squared in Q32.32 rounded up.
    localparam logic signed [66:0] HALF_Q32  = 67'sd1 <<< 31;
    localparam logic signed [66:0] DOT_LIMIT = ((67'sd1 <<< 46) * 67'sd99) / 67'sd100;
    localparam logic signed [66:0] CLOSE_SQ  = 67'sd10737419;
    localparam logic signed [32:0] ONE_Q16   = 33'sd65536;

endpackage

// ----- rtl/core/view_facing_ribbon_trail.sv -----
// Top level of the view-facing ribbon trail builder with its shared datapath.
//
// Usage: a word on the input channel carries a trail position and a forward
// vector (Q16.16). For each accepted word exactly one word leaves on the output
// channel: the top and bottom ribbon points, the outcome code, the ring slot
// written and the head and tail indexes after the step.
// The block works on one word at a time. One 33x33 multiplier with an
// accumulator and one serial subtract unit (one square-root or quotient bit a
// cycle) do all the work. A stored point normalises the forward vector (a
// square root and three divisions), builds the offset from the cross product
// (a second root and three divisions) or from the last points, and wraps the
// ring indexes. The input is ready only while the sequencer idles. The
// finished word sits in an output register, so a stalled receiver holds only
// that word; the block then finishes the next item and waits for it. Reset is
// synchronous: registers return to their reset values, the ring is empty and
// no output word is pending. Configuration is written through the plain write
// port by the user only while the block is idle; the block does not check it.
module view_facing_ribbon_trail
    import vfrt_pkg::*;
#(
    parameter int RING_DEPTH = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_in_word   i_in,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out_word  o_out,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_idx,
    input  logic [30:0] i_cfg_data
);

    localparam int PW = $clog2(RING_DEPTH);
    localparam int EW = (PW + 1 > 7) ? PW + 1 : 7;
    localparam logic [EW-1:0] RING_MAX = EW'(RING_DEPTH);
    localparam logic [EW-1:0] RING_MIN = EW'(2);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_LEN   = 4'd1;
    localparam logic [3:0] ST_SQRT  = 4'd2;
    localparam logic [3:0] ST_DIVN  = 4'd3;
    localparam logic [3:0] ST_DOT   = 4'd4;
    localparam logic [3:0] ST_CROSS = 4'd5;
    localparam logic [3:0] ST_MSQ   = 4'd6;
    localparam logic [3:0] ST_SQRTM = 4'd7;
    localparam logic [3:0] ST_OMUL  = 4'd8;
    localparam logic [3:0] ST_ODIV  = 4'd9;
    localparam logic [3:0] ST_PAR   = 4'd10;
    localparam logic [3:0] ST_TB    = 4'd11;
    localparam logic [3:0] ST_CLOSE = 4'd12;
    localparam logic [3:0] ST_MODH  = 4'd13;
    localparam logic [3:0] ST_MODT  = 4'd14;
    localparam logic [3:0] ST_EMIT  = 4'd15;

    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v > 34'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -34'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = 32'(v);
        end
        return r;
    endfunction

    logic [3:0]         r_state;
    logic [1:0]         r_k;
    logic               r_j;
    logic               r_ph;
    logic [4:0]         r_cnt;
    logic signed [17:0] r_view [3];
    logic [30:0]        r_lw;
    logic [6:0]         r_eiu;
    logic signed [31:0] r_p [3];
    logic signed [31:0] r_f [3];
    logic signed [31:0] r_n [3];
    logic signed [31:0] r_c [3];
    logic signed [31:0] r_o [3];
    logic signed [31:0] r_top [3];
    logic signed [31:0] r_bot [3];
    logic signed [31:0] r_lt [3];
    logic signed [31:0] r_lb [3];
    logic               r_have;
    logic [PW-1:0]      r_head;
    logic [PW-1:0]      r_tail;
    logic [PW-1:0]      r_slot;
    logic [1:0]         r_outcome;
    logic               r_far;
    logic signed [65:0] r_prod;
    logic signed [66:0] r_acc;
    logic [35:0]        r_rem;
    logic [31:0]        r_q;
    logic [63:0]        r_x;
    logic [31:0]        r_dvs;
    logic               r_ovalid;
    t_out_word          r_out;

    // Multiplier operand selection.
    logic signed [32:0] mul_a;
    logic signed [32:0] mul_b;
    logic               mul_neg;
    logic [31:0]        fbits;
    logic [31:0]        fabs;
    logic [31:0]        cbits;
    logic [31:0]        cabs;
    logic signed [32:0] dd_sel;
    logic               dd_far;

    always_comb begin
        fbits  = r_f[r_k];
        fabs   = fbits[31] ? (~fbits + 32'd1) : fbits;
        cbits  = r_c[r_k];
        cabs   = cbits[31] ? (~cbits + 32'd1) : cbits;
        dd_sel = 33'(r_lt[r_k]) - 33'(r_top[r_k]);
        dd_far = (dd_sel >= ONE_Q16) || (dd_sel <= -ONE_Q16);
    end

    always_comb begin
        mul_a   = '0;
        mul_b   = '0;
        mul_neg = 1'b0;
        case (r_state)
            ST_LEN: begin
                mul_a = 33'(r_f[r_k]);
                mul_b = 33'(r_f[r_k]);
            end
            ST_DOT: begin
                mul_a = 33'(r_view[r_k]);
                mul_b = 33'(r_n[r_k]);
            end
            ST_CROSS: begin
                case ({r_k, r_j})
                    3'b000: begin
                        mul_a = 33'(r_n[1]);
                        mul_b = 33'(r_view[2]);
                    end
                    3'b001: begin
                        mul_a   = 33'(r_n[2]);
                        mul_b   = 33'(r_view[1]);
                        mul_neg = 1'b1;
                    end
                    3'b010: begin
                        mul_a = 33'(r_n[2]);
                        mul_b = 33'(r_view[0]);
                    end
                    3'b011: begin
                        mul_a   = 33'(r_n[0]);
                        mul_b   = 33'(r_view[2]);
                        mul_neg = 1'b1;
                    end
                    3'b100: begin
                        mul_a = 33'(r_n[0]);
                        mul_b = 33'(r_view[1]);
                    end
                    3'b101: begin
                        mul_a   = 33'(r_n[1]);
                        mul_b   = 33'(r_view[0]);
                        mul_neg = 1'b1;
                    end
                    default: begin
                        mul_a = '0;
                        mul_b = '0;
                    end
                endcase
            end
            ST_MSQ: begin
                mul_a = 33'(r_c[r_k]);
                mul_b = 33'(r_c[r_k]);
            end
            ST_OMUL: begin
                mul_a = {2'b00, r_lw};
                mul_b = {1'b0, cabs};
            end
            ST_CLOSE: begin
                mul_a = dd_sel;
                mul_b = dd_sel;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    logic signed [66:0] acc_nx;
    logic signed [66:0] cr_adj;
    logic signed [66:0] cr_q;

    always_comb begin
        acc_nx = mul_neg ? (r_acc - 67'(r_prod)) : (r_acc + 67'(r_prod));
        // Division by 2^18 truncates toward zero.
        cr_adj = acc_nx + (acc_nx[66] ? 67'sd262143 : 67'sd0);
        cr_q   = cr_adj >>> 18;
    end

    // Serial unit: one root bit or one quotient bit per cycle.
    logic        sq_mode;
    logic [35:0] sub_a;
    logic [35:0] sub_b;
    logic [36:0] sub_d;
    logic        sub_ge;
    logic [35:0] rem_nx;
    logic [31:0] q_nx;
    logic [63:0] x_nx;

    always_comb begin
        sq_mode = (r_state == ST_SQRT) || (r_state == ST_SQRTM);
        if (sq_mode) begin
            sub_a = {r_rem[33:0], r_x[63:62]};
            sub_b = {2'b00, r_q, 2'b01};
            x_nx  = {r_x[61:0], 2'b00};
        end else begin
            sub_a = {1'b0, r_rem[33:0], r_x[63]};
            sub_b = {4'b0000, r_dvs};
            x_nx  = {r_x[62:0], 1'b0};
        end
        sub_d  = {1'b0, sub_a} - {1'b0, sub_b};
        sub_ge = ~sub_d[36];
        rem_nx = sub_ge ? sub_d[35:0] : sub_a;
        q_nx   = {r_q[30:0], sub_ge};
    end

    // Parallel offsets and ribbon points, one per axis.
    logic signed [31:0] half_c [3];
    logic signed [31:0] top_c [3];
    logic signed [31:0] bot_c [3];
    logic signed [32:0] hd;

    always_comb begin
        hd = '0;
        for (int i = 0; i < 3; i++) begin
            hd        = 33'(r_lt[i]) - 33'(r_lb[i]);
            half_c[i] = 32'((hd + (hd[32] ? 33'sd1 : 33'sd0)) >>> 1);
            top_c[i]  = sat32(34'(r_p[i]) + 34'(r_o[i]));
            bot_c[i]  = sat32(34'(r_p[i]) - 34'(r_o[i]));
        end
    end

    logic [EW-1:0] eiu_w;
    logic [EW-1:0] ring_len;

    always_comb begin
        eiu_w = EW'(r_eiu);
        if (eiu_w < RING_MIN) begin
            ring_len = RING_MIN;
        end else if (eiu_w > RING_MAX) begin
            ring_len = RING_MAX;
        end else begin
            ring_len = eiu_w;
        end
    end

    logic [PW:0]  head_inc;
    logic [PW:0]  tail_inc;
    logic [PW-1:0] mod_res;
    logic          emit_load;

    always_comb begin
        head_inc  = {1'b0, r_head} + {{PW{1'b0}}, 1'b1};
        tail_inc  = {1'b0, r_tail} + {{PW{1'b0}}, 1'b1};
        mod_res   = PW'(rem_nx);
        emit_load = (r_state == ST_EMIT) && (!r_ovalid || i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_k       <= '0;
            r_j       <= 1'b0;
            r_ph      <= 1'b0;
            r_cnt     <= '0;
            r_view[0] <= 18'sd0;
            r_view[1] <= 18'sd0;
            r_view[2] <= 18'sd65536;
            r_lw      <= 31'd65536;
            r_eiu     <= 7'd64;
            r_have    <= 1'b0;
            r_head    <= '0;
            r_tail    <= '0;
            r_far     <= 1'b0;
            r_ovalid  <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                r_lt[i] <= '0;
                r_lb[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_VIEW_X:     r_view[0] <= i_cfg_data[17:0];
                    CFG_VIEW_Y:     r_view[1] <= i_cfg_data[17:0];
                    CFG_VIEW_Z:     r_view[2] <= i_cfg_data[17:0];
                    CFG_LINE_WIDTH: r_lw <= i_cfg_data;
                    CFG_ENTRIES:    r_eiu <= i_cfg_data[6:0];
                    default: ;
                endcase
            end

            if (emit_load) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_p[0] <= i_in.pos_x;
                        r_p[1] <= i_in.pos_y;
                        r_p[2] <= i_in.pos_z;
                        r_f[0] <= i_in.fwd_x;
                        r_f[1] <= i_in.fwd_y;
                        r_f[2] <= i_in.fwd_z;
                        r_k     <= '0;
                        r_ph    <= 1'b0;
                        r_acc   <= '0;
                        r_state <= ST_LEN;
                    end
                end
                ST_LEN, ST_DOT, ST_MSQ, ST_CLOSE: begin
                    if (!r_ph) begin
                        r_prod <= mul_a * mul_b;
                        r_ph   <= 1'b1;
                        if (r_state == ST_CLOSE && dd_far) begin
                            r_far <= 1'b1;
                        end
                    end else begin
                        // The cross products start from a cleared accumulator.
                        r_acc <= (r_state == ST_DOT && r_k == 2'd2) ? '0 : acc_nx;
                        r_ph  <= 1'b0;
                        if (r_k != 2'd2) begin
                            r_k <= r_k + 2'd1;
                        end else begin
                            r_k <= '0;
                            case (r_state)
                                ST_LEN: begin
                                    if (acc_nx < HALF_Q32) begin
                                        r_outcome <= OUT_FAILED;
                                        r_state   <= (r_head != r_tail) ? ST_MODT : ST_EMIT;
                                    end else begin
                                        r_x     <= 64'(acc_nx);
                                        r_rem   <= '0;
                                        r_q     <= '0;
                                        r_cnt   <= '0;
                                        r_state <= ST_SQRT;
                                    end
                                end
                                ST_DOT: begin
                                    r_j   <= 1'b0;
                                    if (acc_nx < DOT_LIMIT) begin
                                        r_state <= ST_CROSS;
                                    end else if (r_have) begin
                                        r_state <= ST_PAR;
                                    end else begin
                                        r_outcome <= OUT_FAILED;
                                        r_state   <= (r_head != r_tail) ? ST_MODT : ST_EMIT;
                                    end
                                end
                                ST_MSQ: begin
                                    r_x     <= 64'(acc_nx);
                                    r_rem   <= '0;
                                    r_q     <= '0;
                                    r_cnt   <= '0;
                                    r_state <= ST_SQRTM;
                                end
                                default: begin
                                    // Closeness test against the last stored top point.
                                    if (!r_far && acc_nx < CLOSE_SQ) begin
                                        r_outcome <= OUT_SKIPPED;
                                        r_state   <= ST_EMIT;
                                    end else begin
                                        r_state <= ST_MODH;
                                    end
                                end
                            endcase
                        end
                    end
                end
                ST_SQRT, ST_SQRTM: begin
                    r_rem <= rem_nx;
                    r_q   <= q_nx;
                    r_x   <= x_nx;
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd31) begin
                        r_dvs <= q_nx;
                        r_k   <= '0;
                        r_ph  <= 1'b0;
                        r_state <= (r_state == ST_SQRT) ? ST_DIVN : ST_OMUL;
                    end
                end
                ST_DIVN: begin
                    if (!r_ph) begin
                        // Dividend is |f| * 2^30; its upper half is below the root.
                        r_rem <= {6'd0, fabs[31:2]};
                        r_x   <= {fabs[1:0], 62'd0};
                        r_q   <= '0;
                        r_cnt <= '0;
                        r_ph  <= 1'b1;
                    end else begin
                        r_rem <= rem_nx;
                        r_q   <= q_nx;
                        r_x   <= x_nx;
                        r_cnt <= r_cnt + 5'd1;
                        if (r_cnt == 5'd31) begin
                            r_n[r_k] <= fbits[31] ? -$signed(q_nx) : $signed(q_nx);
                            r_ph     <= 1'b0;
                            if (r_k != 2'd2) begin
                                r_k <= r_k + 2'd1;
                            end else begin
                                r_k     <= '0;
                                r_acc   <= '0;
                                r_state <= ST_DOT;
                            end
                        end
                    end
                end
                ST_CROSS: begin
                    if (!r_ph) begin
                        r_prod <= mul_a * mul_b;
                        r_ph   <= 1'b1;
                    end else begin
                        r_ph <= 1'b0;
                        if (!r_j) begin
                            r_acc <= acc_nx;
                            r_j   <= 1'b1;
                        end else begin
                            r_c[r_k] <= 32'(cr_q);
                            r_acc    <= '0;
                            r_j      <= 1'b0;
                            if (r_k != 2'd2) begin
                                r_k <= r_k + 2'd1;
                            end else begin
                                r_k     <= '0;
                                r_state <= ST_MSQ;
                            end
                        end
                    end
                end
                ST_OMUL: begin
                    if (r_dvs == 32'd0) begin
                        // A zero cross product leaves no offset.
                        for (int i = 0; i < 3; i++) begin
                            r_o[i] <= '0;
                        end
                        r_state <= ST_TB;
                    end else begin
                        r_prod  <= mul_a * mul_b;
                        r_ph    <= 1'b0;
                        r_state <= ST_ODIV;
                    end
                end
                ST_ODIV: begin
                    if (!r_ph) begin
                        r_rem <= {6'd0, r_prod[61:32]};
                        r_x   <= {r_prod[31:0], 32'd0};
                        r_q   <= '0;
                        r_cnt <= '0;
                        r_ph  <= 1'b1;
                    end else begin
                        r_rem <= rem_nx;
                        r_q   <= q_nx;
                        r_x   <= x_nx;
                        r_cnt <= r_cnt + 5'd1;
                        if (r_cnt == 5'd31) begin
                            r_o[r_k] <= cbits[31] ? -$signed(q_nx) : $signed(q_nx);
                            r_ph     <= 1'b0;
                            if (r_k != 2'd2) begin
                                r_k     <= r_k + 2'd1;
                                r_state <= ST_OMUL;
                            end else begin
                                r_k     <= '0;
                                r_state <= ST_TB;
                            end
                        end
                    end
                end
                ST_PAR: begin
                    for (int i = 0; i < 3; i++) begin
                        r_o[i] <= half_c[i];
                    end
                    r_state <= ST_TB;
                end
                ST_TB: begin
                    for (int i = 0; i < 3; i++) begin
                        r_top[i] <= top_c[i];
                        r_bot[i] <= bot_c[i];
                    end
                    r_k   <= '0;
                    r_ph  <= 1'b0;
                    r_acc <= '0;
                    r_far <= 1'b0;
                    r_state <= r_have ? ST_CLOSE : ST_MODH;
                end
                ST_MODH: begin
                    if (!r_ph) begin
                        r_outcome <= OUT_STORED;
                        r_slot    <= r_head;
                        r_have    <= 1'b1;
                        for (int i = 0; i < 3; i++) begin
                            r_lt[i] <= r_top[i];
                            r_lb[i] <= r_bot[i];
                        end
                        r_dvs <= 32'(ring_len);
                        r_rem <= '0;
                        r_x   <= {32'(head_inc), 32'd0};
                        r_q   <= '0;
                        r_cnt <= '0;
                        r_ph  <= 1'b1;
                    end else begin
                        r_rem <= rem_nx;
                        r_q   <= q_nx;
                        r_x   <= x_nx;
                        r_cnt <= r_cnt + 5'd1;
                        if (r_cnt == 5'd31) begin
                            r_head  <= mod_res;
                            r_ph    <= 1'b0;
                            r_state <= (mod_res == r_tail) ? ST_MODT : ST_EMIT;
                        end
                    end
                end
                ST_MODT: begin
                    if (!r_ph) begin
                        r_dvs <= 32'(ring_len);
                        r_rem <= '0;
                        r_x   <= {32'(tail_inc), 32'd0};
                        r_q   <= '0;
                        r_cnt <= '0;
                        r_ph  <= 1'b1;
                    end else begin
                        r_rem <= rem_nx;
                        r_q   <= q_nx;
                        r_x   <= x_nx;
                        r_cnt <= r_cnt + 5'd1;
                        if (r_cnt == 5'd31) begin
                            r_tail  <= mod_res;
                            r_ph    <= 1'b0;
                            r_state <= ST_EMIT;
                        end
                    end
                end
                ST_EMIT: begin
                    if (emit_load) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Output word register; a failed step reports zero points.
    logic fail_now;

    always_comb begin
        fail_now = (r_outcome == OUT_FAILED);
    end

    always_ff @(posedge i_clk) begin
        if (emit_load) begin
            r_out.top_x      <= fail_now ? 32'sd0 : r_top[0];
            r_out.top_y      <= fail_now ? 32'sd0 : r_top[1];
            r_out.top_z      <= fail_now ? 32'sd0 : r_top[2];
            r_out.bottom_x   <= fail_now ? 32'sd0 : r_bot[0];
            r_out.bottom_y   <= fail_now ? 32'sd0 : r_bot[1];
            r_out.bottom_z   <= fail_now ? 32'sd0 : r_bot[2];
            r_out.outcome    <= r_outcome;
            r_out.slot       <= (r_outcome == OUT_STORED) ? 6'(r_slot) : 6'd0;
            r_out.head_index <= 6'(r_head);
            r_out.tail_index <= 6'(r_tail);
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out       = r_out;

endmodule
